### sv/bcs_pkg.sv
`timescale 1ns / 1ps
package bcs_pkg;
   // Default geometry of the sampler.
   localparam int COORD_WIDTH_DEF = 24;
   localparam int MAX_SAMPLES_DEF = 64;
   localparam int T_FRAC_BITS_DEF = 16;

   // The sample spacing register is fixed at 23 bits, unsigned Q15.8.
   localparam int SPACING_WIDTH = 23;
   localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = 23'd25600;

   // Anchor counter codes.
   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_MANY = 2'd2;

   // Sequencer states.
   localparam int STATE_WIDTH = 3;
   localparam logic [STATE_WIDTH-1:0] ST_IDLE   = 3'd0;
   localparam logic [STATE_WIDTH-1:0] ST_DSTART = 3'd1;
   localparam logic [STATE_WIDTH-1:0] ST_DWAIT  = 3'd2;
   localparam logic [STATE_WIDTH-1:0] ST_LISSUE = 3'd3;
   localparam logic [STATE_WIDTH-1:0] ST_LWAIT  = 3'd4;
   localparam logic [STATE_WIDTH-1:0] ST_OUT    = 3'd5;

   // Number of interpolation steps per sample (six per axis).
   localparam int LERP_STEPS = 12;
   localparam int STEP_WIDTH = 4;

   // Handshake status returned by a shared unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;
endpackage

### sv/bezier_chain_sampler.sv
`timescale 1ns / 1ps
// Streaming cubic Bezier sampler. Anchors enter one transaction at a time; the
// second anchor of a curve closes a segment unless it is the final anchor, and
// each later anchor closes one; a segment is sampled at x steps of
// sample_spacing with de Casteljau interpolation. For each sample the sequencer
// starts the restoring divider and waits until t is ready, then runs twelve
// interpolations through one two-stage multiply unit, then offers the output
// transaction, which the result side may stall. Up to MAX_SAMPLES samples are
// produced per segment; req_tready stays low while a segment runs.
module bezier_chain_sampler #(
   parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
   parameter int MAX_SAMPLES = bcs_pkg::MAX_SAMPLES_DEF,
   parameter int T_FRAC_BITS = bcs_pkg::T_FRAC_BITS_DEF,
   parameter int DATA_WIDTH  = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bcs_pkg::SPACING_WIDTH-1:0]   csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [DATA_WIDTH-1:0]               req_tdata,   // anchor_x, anchor_y
   input  logic                                req_tlast,   // final_anchor
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [DATA_WIDTH-1:0]               rsp_tdata,   // sample_x, sample_y
   output logic                                rsp_tlast,   // segment_end
   output logic                                rsp_tuser    // truncated
);
   import bcs_pkg::*;

   localparam int C   = COORD_WIDTH;
   localparam int SW  = SPACING_WIDTH;
   localparam int PSW = ((C + 1 > SW) ? C + 1 : SW) + 1;
   localparam int MW  = $clog2(MAX_SAMPLES + 1);
   localparam int TW  = ((SW + MW > C + 1) ? SW + MW : C + 1) + 1;
   localparam int NW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

   function automatic logic signed [C-1:0] sat_c(input logic signed [C+1:0] v);
      logic signed [C+1:0] hi;
      logic signed [C+1:0] lo;
      hi = $signed({3'b000, {(C - 1){1'b1}}});
      lo = $signed({3'b111, {(C - 1){1'b0}}});
      if (v > hi) begin
         sat_c = hi[C-1:0];
      end else if (v < lo) begin
         sat_c = lo[C-1:0];
      end else begin
         sat_c = v[C-1:0];
      end
   endfunction

   // Architectural state.
   logic [SW-1:0]         spacing_ff;
   logic [1:0]            seen_ff, seen_in;
   logic signed [C-1:0]   prev_x_ff, prev_y_ff, tan_x_ff, tan_y_ff;
   logic [STATE_WIDTH-1:0] state_ff, state_in;

   // Segment working registers.
   logic signed [C-1:0]   px_ff [4];
   logic signed [C-1:0]   py_ff [4];
   logic signed [C-1:0]   w_ff  [5];
   logic signed [C-1:0]   sx_ff, sy_ff;
   logic [C:0]            dist_ff;
   logic [PSW-1:0]        pos_ff;
   logic [NW-1:0]         n_ff;
   logic                  trunc_ff, last_ff;
   logic [STEP_WIDTH-1:0] step_ff;

   // Anchor entry arithmetic.
   logic signed [C-1:0]   ax, ay;
   logic signed [C:0]     dxw, dyw;
   logic signed [C+2:0]   dy3, qy3;
   logic signed [C:0]     qxs, qys;
   logic signed [C+1:0]   qxe, qye, axe, aye, pxe, pye;
   logic                  first_seg, emit, accept;
   logic [C:0]            span_abs;
   logic [TW-1:0]         need;

   assign ax     = $signed(req_tdata[C-1:0]);
   assign ay     = $signed(req_tdata[2*C-1:C]);
   assign accept = req_tvalid & req_tready;

   always_comb begin
      first_seg = (seen_ff == SEEN_ONE);
      dxw = {ax[C-1], ax} - {prev_x_ff[C-1], prev_x_ff};
      dyw = {ay[C-1], ay} - {prev_y_ff[C-1], prev_y_ff};
      dy3 = {{2{dyw[C]}}, dyw} + {dyw[C], dyw, 1'b0};
      qy3 = dy3 >>> 2;
      qxs = dxw >>> 2;
      qys = dyw >>> 2;
      qxe = {qxs[C], qxs};
      qye = first_seg ? qy3[C+1:0] : {qys[C], qys};
      axe = {{2{ax[C-1]}}, ax};
      aye = {{2{ay[C-1]}}, ay};
      pxe = {{2{prev_x_ff[C-1]}}, prev_x_ff};
      pye = {{2{prev_y_ff[C-1]}}, prev_y_ff};
      span_abs = dxw[C] ? (C + 1)'(-dxw) : dxw;
      need = TW'(MAX_SAMPLES) * TW'(spacing_ff);
      emit = (first_seg && !req_tlast) || (seen_ff == SEEN_MANY);
      if (req_tlast) begin
         seen_in = SEEN_NONE;
      end else if (seen_ff == SEEN_NONE) begin
         seen_in = SEEN_ONE;
      end else begin
         seen_in = SEEN_MANY;
      end
   end

   // Shared units.
   logic                  div_start, lerp_start;
   logic [T_FRAC_BITS-1:0] t_val;
   unit_status_type       div_status, lerp_status;
   logic signed [C-1:0]   la, lb, lres;

   bcs_divider #(.COORD_WIDTH(C), .T_FRAC_BITS(T_FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (pos_ff[C:0]),
      .den   (dist_ff),
      .quot  (t_val),
      .status(div_status)
   );

   bcs_lerp #(.COORD_WIDTH(C), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp (
      .clock (clock),
      .reset (reset),
      .start (lerp_start),
      .a     (la),
      .b     (lb),
      .t     (t_val),
      .result(lres),
      .status(lerp_status)
   );

   // Operand selection for the current interpolation step.
   logic                  on_y;
   logic [2:0]            kstep;
   always_comb begin
      on_y  = (step_ff >= STEP_WIDTH'(LERP_STEPS / 2));
      kstep = on_y ? 3'(step_ff - STEP_WIDTH'(LERP_STEPS / 2)) : step_ff[2:0];
      unique case (kstep)
         3'd0: begin
            la = on_y ? py_ff[0] : px_ff[0];
            lb = on_y ? py_ff[1] : px_ff[1];
         end
         3'd1: begin
            la = on_y ? py_ff[1] : px_ff[1];
            lb = on_y ? py_ff[2] : px_ff[2];
         end
         3'd2: begin
            la = on_y ? py_ff[2] : px_ff[2];
            lb = on_y ? py_ff[3] : px_ff[3];
         end
         3'd3: begin
            la = w_ff[0];
            lb = w_ff[1];
         end
         3'd4: begin
            la = w_ff[1];
            lb = w_ff[2];
         end
         default: begin
            la = w_ff[3];
            lb = w_ff[4];
         end
      endcase
   end

   // Sample position bookkeeping.
   logic [PSW-1:0] pos_next;
   logic           last_sample;
   assign pos_next    = pos_ff + PSW'(spacing_ff);
   assign last_sample = (pos_next >= PSW'(dist_ff)) || (n_ff == NW'(MAX_SAMPLES - 1));

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      div_start  = 1'b0;
      lerp_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && emit && spacing_ff != '0 && span_abs != '0) begin
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_status.done) begin
               state_in = ST_LISSUE;
            end
         end
         ST_LISSUE: begin
            lerp_start = 1'b1;
            state_in   = ST_LWAIT;
         end
         ST_LWAIT: begin
            if (lerp_status.done) begin
               state_in = (step_ff == STEP_WIDTH'(LERP_STEPS - 1)) ? ST_OUT : ST_LISSUE;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = last_ff ? ST_IDLE : ST_DSTART;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      // Segment setup on an accepted anchor.
      if (accept) begin
         px_ff[0] <= prev_x_ff;
         py_ff[0] <= prev_y_ff;
         px_ff[1] <= first_seg ? sat_c(pxe + qxe) : tan_x_ff;
         py_ff[1] <= first_seg ? sat_c(pye + qye) : tan_y_ff;
         px_ff[2] <= sat_c(axe - qxe);
         py_ff[2] <= sat_c(aye - qye);
         px_ff[3] <= ax;
         py_ff[3] <= ay;
         dist_ff  <= span_abs;
         trunc_ff <= (need < TW'(span_abs));
         pos_ff   <= '0;
         n_ff     <= '0;
      end
      if (state_ff == ST_DSTART) begin
         step_ff <= '0;
         last_ff <= last_sample;
      end
      // Store each interpolation result.
      if (state_ff == ST_LWAIT && lerp_status.done) begin
         step_ff <= step_ff + 1'b1;
         if (kstep == 3'd5) begin
            if (on_y) begin
               sy_ff <= lres;
            end else begin
               sx_ff <= lres;
            end
         end else begin
            w_ff[kstep] <= lres;
         end
      end
      if (state_ff == ST_OUT && rsp_tready) begin
         pos_ff <= pos_next;
         n_ff   <= n_ff + 1'b1;
      end
      if (reset) begin
         state_ff   <= ST_IDLE;
         spacing_ff <= SPACING_RESET;
         seen_ff    <= SEEN_NONE;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         tan_x_ff   <= '0;
         tan_y_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            spacing_ff <= csr_wdata;
         end
         if (accept) begin
            seen_ff   <= seen_in;
            prev_x_ff <= ax;
            prev_y_ff <= ay;
            if (seen_ff != SEEN_NONE) begin
               tan_x_ff <= sat_c(axe + qxe);
               tan_y_ff <= sat_c(aye + qye);
            end
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = DATA_WIDTH'({sy_ff, sx_ff});
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = trunc_ff;

   // A sample is never offered while an anchor can be taken.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("sample offered while accepting anchors");

   // Every offered sample lies inside the segment's x span.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (pos_ff < PSW'(dist_ff)))
      else $error("sample position beyond segment span");

   // The last permitted sample always closes the segment.
   a_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && n_ff == NW'(MAX_SAMPLES - 1)) |-> last_ff)
      else $error("sample count exceeds limit");

   // The divider is only started when it is idle.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");
endmodule

### sv/bcs_divider.sv
`timescale 1ns / 1ps
module bcs_divider #(
   parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = bcs_pkg::T_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [COORD_WIDTH:0]   num,
   input  logic [COORD_WIDTH:0]   den,
   output logic [T_FRAC_BITS-1:0] quot,
   output bcs_pkg::unit_status_type status
);
   import bcs_pkg::*;

   localparam int CW = $clog2(T_FRAC_BITS + 1);

   logic [COORD_WIDTH+1:0] rem_ff, rem_in;
   logic [COORD_WIDTH:0]   den_ff, den_in;
   logic [T_FRAC_BITS-1:0] quot_ff, quot_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COORD_WIDTH+1:0] shifted;

   // One restoring quotient bit per cycle.
   always_comb begin
      shifted = {rem_ff[COORD_WIDTH:0], 1'b0};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         quot_in = '0;
         cnt_in  = CW'(T_FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = shifted - {1'b0, den_ff};
            quot_in = {quot_ff[T_FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[T_FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot        = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

### sv/bcs_lerp.sv
`timescale 1ns / 1ps
module bcs_lerp #(
   parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = bcs_pkg::T_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [COORD_WIDTH-1:0] a,
   input  logic signed [COORD_WIDTH-1:0] b,
   input  logic [T_FRAC_BITS-1:0]        t,
   output logic signed [COORD_WIDTH-1:0] result,
   output bcs_pkg::unit_status_type      status
);
   import bcs_pkg::*;

   localparam int PW = COORD_WIDTH + T_FRAC_BITS + 2;

   logic signed [COORD_WIDTH:0]   diff;
   logic signed [PW-1:0]          prod_in, prod_ff;
   logic signed [COORD_WIDTH-1:0] a_ff, res_ff, res_in;
   logic signed [PW-1:0]          scaled;
   logic                          stage_ff, done_ff;

   // First stage: difference times t. Second stage: floor shift and offset.
   always_comb begin
      diff    = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
      prod_in = PW'(diff) * $signed({1'b0, t});
      scaled  = prod_ff >>> T_FRAC_BITS;
      res_in  = a_ff + scaled[COORD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
      if (stage_ff) begin
         res_ff <= res_in;
      end
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         done_ff  <= stage_ff;
      end
   end

   assign result      = res_ff;
   assign status.busy = stage_ff;
   assign status.done = done_ff;
endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
   import bcs_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int TB = T_FRAC_BITS_DEF;
   localparam int MAXS = MAX_SAMPLES_DEF;
   localparam int DW = ((2 * CW + 7) / 8) * 8;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE = 100;
   localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint CMIN = -CMAX - 1;

   typedef struct {
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic                 seg_end;
      logic                 trunc;
   } sample_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [SPACING_WIDTH-1:0] csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DW-1:0]            req_tdata = '0;   // anchor_x, anchor_y
   logic                     req_tlast = 1'b0; // final_anchor
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DW-1:0]            rsp_tdata;        // sample_x, sample_y
   logic                     rsp_tlast;        // segment_end
   logic                     rsp_tuser;        // truncated

   bezier_chain_sampler dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state and the queue of samples still owed by the block.
   sample_type     pending_samples[$];
   longint         spacing_now = SPACING_RESET;
   logic [1:0]     curve_seen = SEEN_NONE;
   longint         last_x = 0, last_y = 0, tan_x = 0, tan_y = 0;
   int             errors = 0;
   int             anchors_sent = 0;
   int             samples_seen = 0;
   int             trunc_segments = 0;
   longint         cycle_count = 0;
   longint         hold_until = 0;
   int             idle_enable = 1;
   int             quiet_cycles = 0;

   function automatic longint clamp(longint v);
      return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
   endfunction

   // a + floor(t * (b - a) / 2^TB), split so the product cannot overflow.
   function automatic longint lerp_fx(longint a, longint b, longint t);
      longint d, dh, dl;
      d = b - a;
      dh = d >>> TB;
      dl = d - (dh <<< TB);
      return a + dh * t + ((dl * t) >>> TB);
   endfunction

   function automatic longint t_of(longint num, longint den);
      longint q, r;
      q = 0;
      r = num;
      for (int b = 0; b < TB; b++) begin
         r = r <<< 1;
         q = q <<< 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   // Samples one cubic segment and queues the points it should produce.
   function automatic void sample_segment(longint cx[4], longint cy[4]);
      longint span, pos, t, ax, ay, bx, by, ex, ey, abx, aby, bcx, bcy;
      int n, first;
      bit trunc;
      sample_type s;
      span = cx[3] - cx[0];
      if (span < 0) span = -span;
      if (spacing_now == 0 || span == 0) return;
      trunc = (MAXS * spacing_now) < span;
      if (trunc) trunc_segments++;
      pos = 0;
      n = 0;
      first = pending_samples.size();
      while (pos < span && n < MAXS) begin
         t = t_of(pos, span);
         ax = lerp_fx(cx[0], cx[1], t); ay = lerp_fx(cy[0], cy[1], t);
         bx = lerp_fx(cx[1], cx[2], t); by = lerp_fx(cy[1], cy[2], t);
         ex = lerp_fx(cx[2], cx[3], t); ey = lerp_fx(cy[2], cy[3], t);
         abx = lerp_fx(ax, bx, t); aby = lerp_fx(ay, by, t);
         bcx = lerp_fx(bx, ex, t); bcy = lerp_fx(by, ey, t);
         s.px = lerp_fx(abx, bcx, t);
         s.py = lerp_fx(aby, bcy, t);
         s.seg_end = 1'b0;
         s.trunc = trunc;
         pending_samples.insert(pending_samples.size(), s);
         n++;
         pos += spacing_now;
      end
      pending_samples[first + n - 1].seg_end = 1'b1;
   endfunction

   // Advances the anchor state for one accepted anchor.
   function automatic void predict_anchor(longint x, longint y, bit fin);
      longint qx, qy;
      longint cx[4], cy[4];
      if (curve_seen == SEEN_NONE) begin
         curve_seen = SEEN_ONE;
      end else if (curve_seen == SEEN_ONE) begin
         qx = (x - last_x) >>> 2;
         qy = ((y - last_y) * 3) >>> 2;
         tan_x = clamp(x + qx);
         tan_y = clamp(y + qy);
         if (!fin) begin
            cx = '{last_x, clamp(last_x + qx), clamp(x - qx), x};
            cy = '{last_y, clamp(last_y + qy), clamp(y - qy), y};
            sample_segment(cx, cy);
         end
         curve_seen = SEEN_MANY;
      end else begin
         qx = (x - last_x) >>> 2;
         qy = (y - last_y) >>> 2;
         cx = '{last_x, tan_x, clamp(x - qx), x};
         cy = '{last_y, tan_y, clamp(y - qy), y};
         sample_segment(cx, cy);
         tan_x = clamp(x + qx);
         tan_y = clamp(y + qy);
      end
      last_x = x;
      last_y = y;
      if (fin) curve_seen = SEEN_NONE;
   endfunction

   function automatic int pick_gap();
      if (!idle_enable) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
      return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
   endfunction

   // Offers one anchor and predicts once the transaction is accepted.
   task automatic send_anchor(longint x, longint y, bit fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {y[CW-1:0], x[CW-1:0]};
      req_tlast <= fin;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      anchors_sent++;
      predict_anchor(x, y, fin);
   endtask

   // Drains the block so the spacing register may be rewritten.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_spacing(longint v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v[SPACING_WIDTH-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      spacing_now = v;
   endtask

   function automatic longint any_coord();
      logic signed [CW-1:0] v;
      v = CW'($urandom());
      return v;
   endfunction

   // Random curve whose x steps are a few spacings, with an occasional wild point.
   task automatic send_curve(int len);
      longint x, y, step;
      step = spacing_now * 6;
      if (step > 4000000) step = 4000000;
      x = any_coord() / 4;
      y = any_coord() / 4;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            x = any_coord();
            y = any_coord();
         end else begin
            x = clamp(x + $signed($urandom_range(0, 2 * step)) - step);
            y = clamp(y + $signed($urandom_range(0, 2 * step)) - step);
         end
         send_anchor(x, y, i == len - 1);
      end
   endtask

   task automatic test_short_curves();
      send_anchor(1000, 2000, 1);
      send_anchor(0, 0, 0);
      send_anchor(51200, 25600, 1);
      send_anchor(0, 0, 0);
      send_anchor(76800, 12800, 0);
      send_anchor(-25600, -51200, 1);
   endtask

   task automatic test_extremes();
      // Control points past full scale must saturate.
      send_anchor(CMIN, CMIN, 0);
      send_anchor(CMAX, CMAX, 0);
      send_anchor(CMIN, CMAX, 0);
      send_anchor(CMAX, CMIN, 1);
      // A zero x span yields nothing, negative x spans run backward.
      send_anchor(5000, 0, 0);
      send_anchor(5000, 9000, 0);
      send_anchor(-40000, -9000, 0);
      send_anchor(-40000, 300, 1);
   endtask

   task automatic test_spacing_extremes();
      set_spacing(1);
      send_anchor(0, 0, 0);
      send_anchor(40, 3, 0);
      send_anchor(100, -7, 1);
      set_spacing((64'd1 << SPACING_WIDTH) - 1);
      send_anchor(CMIN, 0, 0);
      send_anchor(CMAX, 100, 0);
      send_anchor(0, -100, 1);
      set_spacing(256);
      send_anchor(0, 0, 0);
      send_anchor(256 * 200, 5000, 0);
      send_anchor(0, -5000, 1);
   endtask

   task automatic test_backpressure();
      set_spacing(2560);
      hold_until = cycle_count + 3000;
      send_curve(10);
   endtask

   task automatic test_random();
      longint choices[6] = '{1, 256, 1000, 25600, 8388607, 0};
      while (anchors_sent < 400) begin
         choices[5] = $urandom_range(1, 200000);
         set_spacing(choices[$urandom_range(0, 5)]);
         idle_enable = $urandom_range(0, 3) != 0;
         for (int c = 0; c < 6; c++) send_curve($urandom_range(1, 8));
      end
      idle_enable = 1;
   endtask

   // Result side: random stalls, the held-off stretch, and field checks.
   int stall_left = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            samples_seen++;
            if (pending_samples.size() == 0) begin
               $error("unexpected sample x=%0d y=%0d", $signed(rsp_tdata[CW-1:0]),
                      $signed(rsp_tdata[2*CW-1:CW]));
               errors++;
            end else begin
               sample_type e;
               e = pending_samples.pop_front();
               if (rsp_tdata[CW-1:0] !== e.px) begin
                  $error("sample_x expected %0d got %0d", e.px, $signed(rsp_tdata[CW-1:0]));
                  errors++;
               end
               if (rsp_tdata[2*CW-1:CW] !== e.py) begin
                  $error("sample_y expected %0d got %0d", e.py,
                         $signed(rsp_tdata[2*CW-1:CW]));
                  errors++;
               end
               if (rsp_tlast !== e.seg_end) begin
                  $error("segment_end expected %0b got %0b", e.seg_end, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser !== e.trunc) begin
                  $error("truncated expected %0b got %0b", e.trunc, rsp_tuser);
                  errors++;
               end
            end
         end
         if (cycle_count < hold_until) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_curves();
      test_extremes();
      test_spacing_extremes();
      test_backpressure();
      test_random();
      set_spacing(SPACING_RESET);
      send_curve(4);
      wait_idle();
      repeat (SETTLE) @(posedge clock);
      $display("tb: %0d anchors sent, %0d samples checked, %0d truncated segments",
               anchors_sent, samples_seen, trunc_segments);
      $display("tb: spacing swept from 1 to full scale, with held-off result side");
      if (errors == 0 && pending_samples.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
